/* src/tiff_header_ifd_parser_top_macros.svh */
// Assertion macros shared by the checker of the TIFF header parser.
`ifndef TIFF_HEADER_IFD_PARSER_TOP_MACROS_SVH
`define TIFF_HEADER_IFD_PARSER_TOP_MACROS_SVH

// Assertion that is also checked while reset is applied.
`define TIFF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Assertion that is switched off while reset is applied.
`define TIFF_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* src/tiff_hip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TIFF header parser package
// Types, codes and the byte assembly function shared by the parser modules.
// ----------------------------------------------------------------------------
package tiff_hip_pkg;

  // Parsing phases of the back end.
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_COUNT,
    PH_ENTRY,
    PH_IDLE
  } phase_t;

  // Kinds of result word.
  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_ENTRY,
    KIND_ERROR,
    KIND_EMPTY
  } kind_t;

  // Error codes carried by an error result.
  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_BYTE_ORDER,
    ERR_VERSION,
    ERR_OFFSET
  } err_t;

  localparam logic [15:0] MARK_LE    = 16'h4949;
  localparam logic [15:0] MARK_BE    = 16'h4D4D;
  localparam logic [15:0] VERSION    = 16'h002A;
  localparam logic [31:0] HEADER_LEN = 32'd8;
  localparam logic [3:0]  ENTRY_LAST = 4'd11;

  // One input word tagged with its position in the file.
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic [31:0] pos;
  } item_t;

  // Write side of the queue between front and back.
  typedef struct packed {
    logic  push;
    item_t item;
  } qwr_t;

  // Read side of the queue between front and back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qrd_t;

  // Add byte k of a field to the word, in the detected byte order.
  function automatic logic [31:0] take_byte(input logic        le,
                                            input logic [1:0]  k,
                                            input logic [31:0] word,
                                            input logic [7:0]  b);
    logic [31:0] base;
    base = (k == 2'd0) ? 32'd0 : word;
    if (le) begin
      return base | ({24'd0, b} << {k, 3'b000});
    end
    return {base[23:0], b};
  endfunction

endpackage

/* src/tiff_hip_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TIFF parser front end
// Accepts bytes and tags each with its position counted from file start.
// ----------------------------------------------------------------------------
module tiff_hip_front import tiff_hip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] byte_value,
  input  logic       file_start,
  input  logic       q_full,
  output qwr_t       q_wr
);

  logic [31:0] position;
  logic [31:0] pos;
  logic        accept;

  // A new file restarts the position count at this byte.
  assign pos        = file_start ? 32'd0 : position;
  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;

  assign q_wr.push       = accept;
  assign q_wr.item.data  = byte_value;
  assign q_wr.item.start = file_start;
  assign q_wr.item.pos   = pos;

  // Position of the next byte, wrapping at 32 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= 32'd0;
    end else if (accept) begin
      position <= pos + 32'd1;
    end
  end

endmodule

/* src/tiff_hip_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TIFF parser queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tiff_hip_fifo import tiff_hip_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  qwr_t q_wr,
  output logic q_full,
  input  logic pop,
  output qrd_t q_rd
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_pop;

  assign q_full     = (count == 2'd2);
  assign q_rd.valid = (count != 2'd0);
  assign q_rd.item  = slots[rd_ptr];
  assign do_pop     = pop && q_rd.valid;

  // Storage for the queued words.
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slots[wr_ptr] <= q_wr.item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (q_wr.push && !do_pop) begin
        count <= count + 2'd1;
      end else if (!q_wr.push && do_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* src/tiff_hip_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TIFF parser back end
// Parses the header and the first directory and drives the result register.
// ----------------------------------------------------------------------------
module tiff_hip_back import tiff_hip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  qrd_t        q_rd,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [1:0]  error_code,
  output logic        little_endian,
  output logic [15:0] tag_or_version,
  output logic [15:0] data_type,
  output logic [31:0] value_count,
  output logic [31:0] offset_or_value,
  output logic [15:0] entry_index,
  output logic        last_entry
);

  // Parser state.
  phase_t      phase, phase_next;
  logic [3:0]  bif, bif_next;
  logic        endian, endian_next;
  logic [31:0] word, word_next;
  logic [31:0] dir_off, dir_off_next;
  logic [15:0] total, total_next;
  logic [15:0] done, done_next;
  logic [15:0] p_tag, p_tag_next;
  logic [15:0] p_type, p_type_next;
  logic [31:0] p_count, p_count_next;

  // Effective state after a possible file restart.
  phase_t      e_phase;
  logic [3:0]  e_bif;
  logic        e_endian;
  logic [31:0] e_word;
  logic [31:0] e_dir;
  logic [15:0] e_total;
  logic [15:0] e_done;
  logic [15:0] e_tag;
  logic [15:0] e_type;
  logic [31:0] e_count;

  logic        start;
  logic [7:0]  b;
  logic        go;
  logic        emit;
  kind_t       r_kind;
  err_t        r_err;
  logic        r_le;
  logic [15:0] r_tag;
  logic [15:0] r_type;
  logic [31:0] r_count;
  logic [31:0] r_off;
  logic [15:0] r_index;
  logic        r_last;
  logic [15:0] mark;
  logic [3:0]  p;
  logic [1:0]  k;
  logic [15:0] done_inc;
  logic        last;

  assign start = q_rd.item.start;
  assign b     = q_rd.item.data;

  // A word is taken whenever the result register is free or being drained.
  assign go  = q_rd.valid && (!result_valid || !result_stall);
  assign pop = go;

  // A restart behaves as if every state register had just been cleared.
  always_comb begin
    if (start) begin
      e_phase  = PH_HEADER;
      e_bif    = 4'd0;
      e_endian = 1'b0;
      e_word   = 32'd0;
      e_dir    = 32'd0;
      e_total  = 16'd0;
      e_done   = 16'd0;
      e_tag    = 16'd0;
      e_type   = 16'd0;
      e_count  = 32'd0;
    end else begin
      e_phase  = phase;
      e_bif    = bif;
      e_endian = endian;
      e_word   = word;
      e_dir    = dir_off;
      e_total  = total;
      e_done   = done;
      e_tag    = p_tag;
      e_type   = p_type;
      e_count  = p_count;
    end
  end

  // Next state and result for the word at the head of the queue.
  always_comb begin
    phase_next   = e_phase;
    bif_next     = e_bif;
    endian_next  = e_endian;
    word_next    = e_word;
    dir_off_next = e_dir;
    total_next   = e_total;
    done_next    = e_done;
    p_tag_next   = e_tag;
    p_type_next  = e_type;
    p_count_next = e_count;
    emit    = 1'b0;
    r_kind  = KIND_HEADER;
    r_err   = ERR_NONE;
    r_le    = 1'b0;
    r_tag   = 16'd0;
    r_type  = 16'd0;
    r_count = 32'd0;
    r_off   = 32'd0;
    r_index = 16'd0;
    r_last  = 1'b0;
    mark     = {e_word[7:0], b};
    p        = 4'd0;
    k        = 2'd0;
    done_inc = e_done + 16'd1;
    last     = 1'b0;

    if (e_phase == PH_HEADER) begin
      bif_next = e_bif + 4'd1;
      if (e_bif == 4'd0) begin
        word_next = {24'd0, b};
      end else if (e_bif == 4'd1) begin
        // Byte-order mark.
        if (mark == MARK_LE) begin
          endian_next = 1'b1;
        end else if (mark == MARK_BE) begin
          endian_next = 1'b0;
        end else begin
          endian_next = 1'b0;
          emit        = 1'b1;
          r_kind      = KIND_ERROR;
          r_err       = ERR_BYTE_ORDER;
          r_tag       = mark;
          phase_next  = PH_IDLE;
          bif_next    = 4'd0;
        end
      end else if (e_bif <= 4'd3) begin
        // Version word.
        word_next = take_byte(e_endian, {1'b0, e_bif[0]}, e_word, b);
        if (e_bif == 4'd3 && word_next[15:0] != VERSION) begin
          emit       = 1'b1;
          r_kind     = KIND_ERROR;
          r_err      = ERR_VERSION;
          r_le       = e_endian;
          r_tag      = word_next[15:0];
          phase_next = PH_IDLE;
          bif_next   = 4'd0;
        end
      end else begin
        // First directory offset.
        word_next = take_byte(e_endian, e_bif[1:0], e_word, b);
        if (e_bif >= 4'd7) begin
          dir_off_next = word_next;
          bif_next     = 4'd0;
          emit         = 1'b1;
          r_le         = e_endian;
          r_off        = word_next;
          if (word_next < HEADER_LEN) begin
            r_kind     = KIND_ERROR;
            r_err      = ERR_OFFSET;
            phase_next = PH_IDLE;
          end else begin
            r_kind     = KIND_HEADER;
            r_tag      = VERSION;
            phase_next = PH_SKIP;
          end
        end
      end
    end else begin
      // The skip ends on the byte at the directory offset.
      if (e_phase == PH_SKIP && q_rd.item.pos == e_dir) begin
        phase_next = PH_COUNT;
        bif_next   = 4'd0;
      end
      if (phase_next == PH_COUNT) begin
        k         = {1'b0, bif_next[0]};
        word_next = take_byte(e_endian, k, e_word, b);
        bif_next  = {3'd0, bif_next[0]} + 4'd1;
        if (k == 2'd1) begin
          total_next = word_next[15:0];
          done_next  = 16'd0;
          bif_next   = 4'd0;
          if (word_next[15:0] == 16'd0) begin
            emit       = 1'b1;
            r_kind     = KIND_EMPTY;
            r_le       = e_endian;
            r_off      = e_dir;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_ENTRY;
          end
        end
      end else if (phase_next == PH_ENTRY) begin
        // Entry layout: tag, type, count, value or offset.
        p         = (e_bif > ENTRY_LAST) ? ENTRY_LAST : e_bif;
        k         = (p == 4'd2 || p == 4'd3) ? {1'b0, p[0]} : p[1:0];
        word_next = take_byte(e_endian, k, e_word, b);
        bif_next  = p + 4'd1;
        if (p == 4'd1) begin
          p_tag_next = word_next[15:0];
        end else if (p == 4'd3) begin
          p_type_next = word_next[15:0];
        end else if (p == 4'd7) begin
          p_count_next = word_next;
        end else if (p == ENTRY_LAST) begin
          last      = (done_inc == e_total);
          emit      = 1'b1;
          r_kind    = KIND_ENTRY;
          r_le      = e_endian;
          r_tag     = e_tag;
          r_type    = e_type;
          r_count   = e_count;
          r_off     = word_next;
          r_index   = e_done;
          r_last    = last;
          done_next = done_inc;
          bif_next  = 4'd0;
          if (last) begin
            phase_next = PH_IDLE;
          end
        end
      end
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEADER;
      bif     <= 4'd0;
      endian  <= 1'b0;
      word    <= 32'd0;
      dir_off <= 32'd0;
      total   <= 16'd0;
      done    <= 16'd0;
      p_tag   <= 16'd0;
      p_type  <= 16'd0;
      p_count <= 32'd0;
    end else if (go) begin
      phase   <= phase_next;
      bif     <= bif_next;
      endian  <= endian_next;
      word    <= word_next;
      dir_off <= dir_off_next;
      total   <= total_next;
      done    <= done_next;
      p_tag   <= p_tag_next;
      p_type  <= p_type_next;
      p_count <= p_count_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (go && emit) begin
      kind            <= r_kind;
      error_code      <= r_err;
      little_endian   <= r_le;
      tag_or_version  <= r_tag;
      data_type       <= r_type;
      value_count     <= r_count;
      offset_or_value <= r_off;
      entry_index     <= r_index;
      last_entry      <= r_last;
    end
  end

endmodule

/* src/tiff_header_ifd_parser_top.sv */
`timescale 1ns / 1ps
// Result path: the completing byte is queued, then its result word is registered.
// Throughput: one byte per cycle; the back end takes one queued byte each cycle that
// the result register is free or drained.
// Reset: synchronous; clears the queue, position count and parser to the header phase.
// Result stall only reaches the input once the two-entry queue has filled.
// ----------------------------------------------------------------------------
// TIFF header and directory parser
// Front end, two-entry queue and parsing back end with a result register.
// ----------------------------------------------------------------------------
module tiff_header_ifd_parser_top import tiff_hip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_value,
  input  logic        file_start,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [1:0]  error_code,
  output logic        little_endian,
  output logic [15:0] tag_or_version,
  output logic [15:0] data_type,
  output logic [31:0] value_count,
  output logic [31:0] offset_or_value,
  output logic [15:0] entry_index,
  output logic        last_entry
);

  qwr_t q_wr;
  qrd_t q_rd;
  logic q_full;
  logic pop;

  // Position tagging.
  tiff_hip_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_value (byte_value),
    .file_start (file_start),
    .q_full     (q_full),
    .q_wr       (q_wr)
  );

  // Decoupling queue.
  tiff_hip_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .pop    (pop),
    .q_rd   (q_rd)
  );

  // Parser and result register.
  tiff_hip_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_rd            (q_rd),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .kind            (kind),
    .error_code      (error_code),
    .little_endian   (little_endian),
    .tag_or_version  (tag_or_version),
    .data_type       (data_type),
    .value_count     (value_count),
    .offset_or_value (offset_or_value),
    .entry_index     (entry_index),
    .last_entry      (last_entry)
  );

endmodule

/* src/tiff_hip_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TIFF parser port checker
// Watches the top-level ports and checks reset and result behaviour.
// ----------------------------------------------------------------------------
`include "tiff_header_ifd_parser_top_macros.svh"

module tiff_hip_checker import tiff_hip_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        byte_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  kind,
  input logic [1:0]  error_code,
  input logic [15:0] tag_or_version
);

  // After reset there is no result and the input side is open.
  `TIFF_ASSERT(a_reset_no_result, rst |=> !result_valid, "result word after reset")
  `TIFF_ASSERT(a_reset_open, rst |=> !byte_stall, "input stalled after reset")

  // A stalled result word is held.
  `TIFF_ASSERT_NR(a_hold, result_valid && result_stall |=> result_valid && $stable(kind), "stalled result word changed")

  // A header word carries the version and no error code.
  `TIFF_ASSERT_NR(a_header, result_valid && kind == KIND_HEADER |-> error_code == ERR_NONE && tag_or_version == VERSION, "malformed header word")

endmodule

bind tiff_header_ifd_parser_top tiff_hip_checker u_checker (.*);

/* dv/tiff_header_ifd_parser_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TIFF header and directory parser testbench
// Feeds byte streams into the parser and checks every result word against a
// cycle-free predictor of the header, skip, count and entry phases. A short
// table covers the error codes, the header and the empty directory; random
// files with occasional corruption, truncation and noise follow, under
// varying idle patterns on both sides.
// ----------------------------------------------------------------------------
module tiff_header_ifd_parser_top_tb import tiff_hip_pkg::*;;

  // One result word as the parser presents it.
  typedef struct packed {
    kind_t       kind;
    err_t        code;
    logic        le;
    logic [15:0] tag;
    logic [15:0] dtype;
    logic [31:0] cnt;
    logic [31:0] val;
    logic [15:0] idx;
    logic        last;
  } result_t;

  // One row of the directed table; a typed row carries its own expectation.
  typedef struct packed {
    logic [7:0] b;
    logic       s;
    logic       typed;
    result_t    want;
  } stim_row_t;

  // Predictor state of the parser.
  typedef struct packed {
    phase_t      ph;
    logic [31:0] next_pos;
    logic [3:0]  field_byte;
    logic        le;
    logic [31:0] acc;
    logic [31:0] dir_off;
    logic [15:0] n_total;
    logic [15:0] n_done;
    logic [15:0] tag;
    logic [15:0] dtype;
    logic [31:0] cnt;
  } ifd_state_t;

  localparam result_t NO_WORD   = '0;
  localparam int      LIVE_GOAL = 1650;
  localparam int      HOLD_LEN  = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  byte_value;
  logic        file_start;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  kind;
  logic [1:0]  error_code;
  logic        little_endian;
  logic [15:0] tag_or_version;
  logic [15:0] data_type;
  logic [31:0] value_count;
  logic [31:0] offset_or_value;
  logic [15:0] entry_index;
  logic        last_entry;

  ifd_state_t  ifd_state;
  result_t     pending_words[$];
  logic [7:0]  file_bytes[$];
  stim_row_t   directed_rows[24];
  int          mismatches = 0;
  int          live_bytes = 0;
  int          tx_idle_pct = 33;
  int          rx_idle_pct = 72;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  tiff_header_ifd_parser_top dut (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .byte_value     (byte_value),
    .file_start     (file_start),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .error_code     (error_code),
    .little_endian  (little_endian),
    .tag_or_version (tag_or_version),
    .data_type      (data_type),
    .value_count    (value_count),
    .offset_or_value(offset_or_value),
    .entry_index    (entry_index),
    .last_entry     (last_entry)
  );

  always #5 clk = ~clk;

  // Builds a result word with only the fields used by header and error words.
  function automatic result_t mk_result(input kind_t k, input err_t e, input logic le,
                                        input logic [15:0] tv, input logic [31:0] ov);
    result_t r;
    r = '0;
    r.kind = k;
    r.code = e;
    r.le = le;
    r.tag = tv;
    r.val = ov;
    return r;
  endfunction

  function automatic string word_text(input result_t w);
    return $sformatf("kind %0d err %0d le %0d tag %h type %h count %h value %h idx %0d last %0d",
                     w.kind, w.code, w.le, w.tag, w.dtype, w.cnt, w.val, w.idx, w.last);
  endfunction

  // Merges byte k of a multi-byte field in the byte order of the file.
  function automatic logic [31:0] fold_byte(input logic le, input int unsigned k,
                                            input logic [31:0] w, input logic [7:0] b);
    logic [31:0] base;
    base = (k == 0) ? 32'd0 : w;
    if (le) begin
      return base | ({24'd0, b} << (8 * k));
    end
    return {base[23:0], b};
  endfunction

  // Advances the predictor by one byte; returns 1 when a result word is due.
  function automatic bit parse_byte(input logic [7:0] b, input logic s, output result_t r);
    logic [31:0] pos;
    logic [3:0]  p;
    logic [15:0] mark;
    logic [15:0] nxt;
    int unsigned k;
    bit          got;
    got = 0;
    r = '0;
    if (s) begin
      ifd_state = '0;
      ifd_state.ph = PH_HEADER;
    end
    pos = ifd_state.next_pos;
    ifd_state.next_pos = ifd_state.next_pos + 32'd1;
    if (ifd_state.ph == PH_HEADER) begin
      p = ifd_state.field_byte;
      ifd_state.field_byte = p + 4'd1;
      if (p == 0) begin
        ifd_state.acc = {24'd0, b};
      end else if (p == 1) begin
        // Byte-order mark.
        mark = {ifd_state.acc[7:0], b};
        if (mark == MARK_LE) begin
          ifd_state.le = 1'b1;
        end else if (mark == MARK_BE) begin
          ifd_state.le = 1'b0;
        end else begin
          ifd_state.le = 1'b0;
          r.kind = KIND_ERROR;
          r.code = ERR_BYTE_ORDER;
          r.tag = mark;
          got = 1;
          ifd_state.ph = PH_IDLE;
          ifd_state.field_byte = 0;
        end
      end else if (p <= 3) begin
        // Version word.
        ifd_state.acc = fold_byte(ifd_state.le, p - 2, ifd_state.acc, b);
        if (p == 3 && ifd_state.acc[15:0] != VERSION) begin
          r.kind = KIND_ERROR;
          r.code = ERR_VERSION;
          r.le = ifd_state.le;
          r.tag = ifd_state.acc[15:0];
          got = 1;
          ifd_state.ph = PH_IDLE;
          ifd_state.field_byte = 0;
        end
      end else begin
        // First directory offset.
        ifd_state.acc = fold_byte(ifd_state.le, p - 4, ifd_state.acc, b);
        if (p >= 7) begin
          ifd_state.dir_off = ifd_state.acc;
          ifd_state.field_byte = 0;
          r.le = ifd_state.le;
          r.val = ifd_state.dir_off;
          got = 1;
          if (ifd_state.dir_off < HEADER_LEN) begin
            r.kind = KIND_ERROR;
            r.code = ERR_OFFSET;
            ifd_state.ph = PH_IDLE;
          end else begin
            r.kind = KIND_HEADER;
            r.tag = VERSION;
            ifd_state.ph = PH_SKIP;
          end
        end
      end
    end else begin
      if (ifd_state.ph == PH_SKIP && pos == ifd_state.dir_off) begin
        ifd_state.ph = PH_COUNT;
        ifd_state.field_byte = 0;
      end
      if (ifd_state.ph == PH_COUNT) begin
        // Two-byte entry count.
        p = {3'd0, ifd_state.field_byte[0]};
        ifd_state.acc = fold_byte(ifd_state.le, 32'(p), ifd_state.acc, b);
        ifd_state.field_byte = p + 4'd1;
        if (p == 1) begin
          ifd_state.n_total = ifd_state.acc[15:0];
          ifd_state.n_done = 0;
          ifd_state.field_byte = 0;
          if (ifd_state.n_total == 0) begin
            r.kind = KIND_EMPTY;
            r.le = ifd_state.le;
            r.val = ifd_state.dir_off;
            got = 1;
            ifd_state.ph = PH_IDLE;
          end else begin
            ifd_state.ph = PH_ENTRY;
          end
        end
      end else if (ifd_state.ph == PH_ENTRY) begin
        // Twelve-byte directory entry: tag, type, count, value.
        p = (ifd_state.field_byte > ENTRY_LAST) ? ENTRY_LAST : ifd_state.field_byte;
        k = (p < 2) ? p : (p < 4) ? p - 2 : (p < 8) ? p - 4 : p - 8;
        ifd_state.acc = fold_byte(ifd_state.le, k, ifd_state.acc, b);
        ifd_state.field_byte = p + 4'd1;
        if (p == 1) begin
          ifd_state.tag = ifd_state.acc[15:0];
        end else if (p == 3) begin
          ifd_state.dtype = ifd_state.acc[15:0];
        end else if (p == 7) begin
          ifd_state.cnt = ifd_state.acc;
        end else if (p == ENTRY_LAST) begin
          nxt = ifd_state.n_done + 16'd1;
          r.kind = KIND_ENTRY;
          r.le = ifd_state.le;
          r.tag = ifd_state.tag;
          r.dtype = ifd_state.dtype;
          r.cnt = ifd_state.cnt;
          r.val = ifd_state.acc;
          r.idx = ifd_state.n_done;
          r.last = (nxt == ifd_state.n_total);
          got = 1;
          ifd_state.n_done = nxt;
          ifd_state.field_byte = 0;
          if (nxt == ifd_state.n_total) begin
            ifd_state.ph = PH_IDLE;
          end
        end
      end
    end
    return got;
  endfunction

  // Appends a field of one, two or four bytes in the given byte order.
  function automatic void put_field(input logic [31:0] v, input int nbytes, input bit le);
    for (int i = 0; i < nbytes; i++) begin
      if (le) begin
        file_bytes.push_back(v[8*i +: 8]);
      end else begin
        file_bytes.push_back(v[8*(nbytes-1-i) +: 8]);
      end
    end
  endfunction

  // Builds one random file: mostly well formed, sometimes corrupt or cut short.
  function automatic void build_file();
    int          pick;
    int          n_entries;
    int          cut;
    bit          le;
    logic [31:0] offset;
    file_bytes.delete();
    pick = $urandom_range(99);
    le = 1'($urandom_range(1));
    if (pick < 5) begin
      put_field($urandom, 2, 1'b0);
    end else begin
      put_field({16'd0, le ? MARK_LE : MARK_BE}, 2, 1'b0);
    end
    if (pick >= 5 && pick < 10) begin
      put_field($urandom, 2, le);
    end else begin
      put_field({16'd0, VERSION}, 2, le);
    end
    if (pick >= 10 && pick < 15) begin
      offset = $urandom_range(7);
    end else if (pick >= 15 && pick < 18) begin
      offset = $urandom;
    end else if (pick >= 18 && pick < 23) begin
      offset = 8 + $urandom_range(64);
    end else begin
      offset = 8 + $urandom_range(6);
    end
    put_field(offset, 4, le);
    while (file_bytes.size() < offset && file_bytes.size() < 80) begin
      file_bytes.push_back(8'($urandom_range(255)));
    end
    n_entries = (pick >= 95) ? $urandom_range(65535) : $urandom_range(5);
    put_field(n_entries, 2, le);
    for (int i = 0; i < n_entries && i < 8; i++) begin
      repeat (12) file_bytes.push_back(8'($urandom_range(255)));
    end
    repeat ($urandom_range(2)) file_bytes.push_back(8'($urandom_range(255)));
    // A cut file is followed by a restart in the middle of parsing.
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(file_bytes.size() - 1, 1);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endfunction

  // Offers one word on the input side and predicts its result once accepted.
  task automatic offer_byte(input logic [7:0] b, input logic s, input logic typed,
                            input result_t want);
    result_t predicted;
    bit      has;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_valid = 1'b0;
      @(negedge clk);
    end
    byte_valid = 1'b1;
    byte_value = b;
    file_start = s;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    live_bytes++;
    has = parse_byte(b, s, predicted);
    if (typed) begin
      pending_words.push_back(want);
    end else if (has) begin
      pending_words.push_back(predicted);
    end
  endtask

  // Result side stall: random, or a long counted hold-off on request.
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      result_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t exp;
    if (!rst && result_valid && !result_stall) begin
      got.kind = kind_t'(kind);
      got.code = err_t'(error_code);
      got.le = little_endian;
      got.tag = tag_or_version;
      got.dtype = data_type;
      got.cnt = value_count;
      got.val = offset_or_value;
      got.idx = entry_index;
      got.last = last_entry;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %s", word_text(got));
      end else begin
        exp = pending_words.pop_front();
        if (got.kind !== exp.kind || got.code !== exp.code || got.le !== exp.le ||
            got.tag !== exp.tag || got.dtype !== exp.dtype || got.cnt !== exp.cnt ||
            got.val !== exp.val || got.idx !== exp.idx || got.last !== exp.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result word mismatch at %0t", $realtime);
            $display("  expected: %s", word_text(exp));
            $display("  actual:   %s", word_text(got));
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int stage;
    int drain;
    int left_over;
    stage = 0;
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_value = 8'd0;
    file_start = 1'b0;
    ifd_state = '0;
    ifd_state.ph = PH_HEADER;

    directed_rows = '{
      // No file start after reset: big-endian mark, then a wrong version.
      '{8'h4D, 1'b0, 1'b0, NO_WORD},
      '{8'h4D, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h2B, 1'b0, 1'b1, mk_result(KIND_ERROR, ERR_VERSION, 1'b0, 16'h002B, 32'd0)},
      // Bad byte-order mark built from the extreme byte values.
      '{8'hFF, 1'b1, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, mk_result(KIND_ERROR, ERR_BYTE_ORDER, 1'b0, 16'hFF00, 32'd0)},
      // Little-endian header whose offset points inside the header.
      '{8'h49, 1'b1, 1'b0, NO_WORD},
      '{8'h49, 1'b0, 1'b0, NO_WORD},
      '{8'h2A, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h07, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, mk_result(KIND_ERROR, ERR_OFFSET, 1'b1, 16'h0000, 32'd7)},
      // Big-endian header, offset of exactly eight, then an empty directory.
      '{8'h4D, 1'b1, 1'b0, NO_WORD},
      '{8'h4D, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h2A, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h08, 1'b0, 1'b1, mk_result(KIND_HEADER, ERR_NONE, 1'b0, VERSION, 32'd8)},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, mk_result(KIND_EMPTY, ERR_NONE, 1'b0, 16'h0000, 32'd8)}
    };

    repeat (10) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      offer_byte(directed_rows[i].b, directed_rows[i].s, directed_rows[i].typed,
                 directed_rows[i].want);
    end

    // Random files; the idle pattern changes by thirds of the run.
    while (live_bytes < LIVE_GOAL) begin
      if (stage == 0 && live_bytes >= LIVE_GOAL / 3) begin
        stage = 1;
        tx_idle_pct = 72;
        rx_idle_pct = 33;
      end else if (stage == 1 && live_bytes >= 2 * LIVE_GOAL / 3) begin
        stage = 2;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // Let the parser drain completely, then hold the result side off
        // while words keep coming so that the input stalls.
        @(negedge clk);
        byte_valid = 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        hold_requests++;
      end
      if ($urandom_range(19) == 0) begin
        repeat ($urandom_range(4, 1)) begin
          offer_byte(8'($urandom_range(255)), 1'b0, 1'b0, NO_WORD);
        end
      end
      build_file();
      foreach (file_bytes[i]) offer_byte(file_bytes[i], i == 0, 1'b0, NO_WORD);
    end

    @(negedge clk);
    byte_valid = 1'b0;
    file_start = 1'b0;
    drain = 0;
    while (pending_words.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    left_over = pending_words.size();
    if (left_over != 0) $display("%0d expected result words never arrived", left_over);
    if (mismatches == 0 && left_over == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("run limit reached");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
